### sv/ssp_pkg.sv
// ============================================================================
// ssp_pkg - shared types and constants for the servo slew positioner
// Request kinds, register indexes, character codes and angle limits.
// ============================================================================
package ssp_pkg;

  // Field widths
  localparam int unsigned ANGLE_W    = 8;
  localparam int unsigned INTERVAL_W = 10;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

  // Angle limits in degrees
  localparam logic [ANGLE_W-1:0] MAX_ANGLE  = 8'd180;
  localparam logic [ANGLE_W-1:0] HOME_ANGLE = 8'd90;

  // Register reset values
  localparam logic [INTERVAL_W-1:0]   STEP_INTERVAL_RST = 10'd15;
  localparam logic [ANGLE_W-1:0]      STEP_SIZE_RST     = 8'd1;
  localparam logic [ANGLE_W-1:0]      COOL_ANGLE_RST    = 8'd90;
  localparam logic [ANGLE_W-1:0]      HOT_ANGLE_RST     = 8'd0;
  // 30.0 and 50.0 degC in 1/16 degC
  localparam logic signed [TEMP_W-1:0] LOW_THR_RST      = 12'sd480;
  localparam logic signed [TEMP_W-1:0] HIGH_THR_RST     = 12'sd800;

  // Serial character codes
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_M = 8'h6D;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_M = 8'h4D;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_9 = 8'h39;

  // Request kinds
  typedef enum logic [IN_USER_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_TEMP = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_INTERVAL = 3'd0,
    REG_STEP_SIZE     = 3'd1,
    REG_COOL_ANGLE    = 3'd2,
    REG_HOT_ANGLE     = 3'd3,
    REG_LOW_THRESHOLD = 3'd4,
    REG_HIGH_THRESHOLD = 3'd5
  } reg_idx_t;

  // Saturate an angle at the mechanical limit
  function automatic logic [ANGLE_W-1:0] clip_angle(input logic [ANGLE_W-1:0] a);
    clip_angle = (a > MAX_ANGLE) ? MAX_ANGLE : a;
  endfunction

endpackage

### sv/servo_slew_positioner_top.sv
// ============================================================================
// servo_slew_positioner_top - servo angle positioner with slew limiting
// Tick, serial byte and temperature requests update the angle and target.
// ============================================================================
// Usage:
//   Input stream (s_axis_*): one request per transfer. tuser carries the
//   request kind (tick, serial byte, temperature); tdata carries the serial
//   byte and the signed temperature sample.
//   Output stream (m_axis_*): one result per request, in order: current
//   angle, angle-changed flag, manual mode flag and target angle.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per cycle;
//   write only while no request is in flight.
// Timing and throughput:
//   A request is decoded and the state updated in the cycle it is accepted;
//   its result appears on m_axis in the next cycle. One request per cycle is
//   sustained while m_axis_tready stays high, set by the single output register.
// Reset:
//   rst returns the registers to their defaults, the angle and target to
//   90 degrees, auto mode, and empties the output register.
// Stall:
//   While a result waits, s_axis_tready stays high only if m_axis_tready
//   frees the output register in the same cycle.
module servo_slew_positioner_top
  import ssp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Request stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_code, [19:8] temperature
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [1:0] cmd
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // [7:0] servo_angle, [8] servo_write,
                                                // [9] mode_bit, [17:10] target_angle
);

  // Configuration registers
  logic [INTERVAL_W-1:0]      step_interval;
  logic [ANGLE_W-1:0]         step_size;
  logic [ANGLE_W-1:0]         cool_angle;
  logic [ANGLE_W-1:0]         hot_angle;
  logic signed [TEMP_W-1:0]   low_threshold;
  logic signed [TEMP_W-1:0]   high_threshold;

  // Positioner state
  logic                       mode_flag, mode_flag_next;
  logic [ANGLE_W-1:0]         current_angle, current_angle_next;
  logic [ANGLE_W-1:0]         target, target_next;
  logic [INTERVAL_W-1:0]      tick_count, tick_count_next;
  logic [ANGLE_W-1:0]         digit_acc, digit_acc_next;
  logic                       number_pending, number_pending_next;

  // Request fields
  cmd_t                       in_cmd;
  logic [CHAR_W-1:0]          in_char;
  logic signed [TEMP_W-1:0]   in_temp;
  logic                       in_accept;

  // Working values
  logic [INTERVAL_W:0]        tick_sum;
  logic [ANGLE_W-1:0]         angle_diff;
  logic [ANGLE_W-1:0]         angle_move;
  logic [10:0]                digit_sum;

  // Output register
  logic                       out_valid;
  logic [OUT_DATA_W-1:0]      out_data;

  assign in_cmd    = cmd_t'(s_axis_tuser);
  assign in_char   = s_axis_tdata[7:0];
  assign in_temp   = s_axis_tdata[19:8];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval  <= STEP_INTERVAL_RST;
      step_size      <= STEP_SIZE_RST;
      cool_angle     <= COOL_ANGLE_RST;
      hot_angle      <= HOT_ANGLE_RST;
      low_threshold  <= LOW_THR_RST;
      high_threshold <= HIGH_THR_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_STEP_INTERVAL:  step_interval  <= cfg_data[INTERVAL_W-1:0];
        REG_STEP_SIZE:      step_size      <= cfg_data[ANGLE_W-1:0];
        REG_COOL_ANGLE:     cool_angle     <= cfg_data[ANGLE_W-1:0];
        REG_HOT_ANGLE:      hot_angle      <= cfg_data[ANGLE_W-1:0];
        REG_LOW_THRESHOLD:  low_threshold  <= cfg_data;
        REG_HIGH_THRESHOLD: high_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Slew step toward target, clipped so it never overshoots
  always_comb begin
    angle_diff = (current_angle < target) ? (target - current_angle)
                                          : (current_angle - target);
    angle_move = (step_size < angle_diff) ? step_size : angle_diff;
  end

  // Accumulate decimal digit: acc*10 + digit
  assign tick_sum  = {1'b0, tick_count} + {{INTERVAL_W{1'b0}}, 1'b1};
  assign digit_sum = {digit_acc, 3'b000} + {2'b00, digit_acc, 1'b0}
                   + {7'd0, in_char[3:0]};

  // Decode request and compute next state
  always_comb begin
    mode_flag_next      = mode_flag;
    current_angle_next  = current_angle;
    target_next         = target;
    tick_count_next     = tick_count;
    digit_acc_next      = digit_acc;
    number_pending_next = number_pending;
    case (in_cmd)
      CMD_TICK: begin
        if (tick_sum >= {1'b0, step_interval}) begin
          tick_count_next = '0;
          if (current_angle < target) begin
            current_angle_next = current_angle + angle_move;
          end else if (current_angle > target) begin
            current_angle_next = current_angle - angle_move;
          end
        end else begin
          tick_count_next = tick_sum[INTERVAL_W-1:0];
        end
      end
      CMD_BYTE: begin
        if (in_char >= CHAR_DIGIT_0 && in_char <= CHAR_DIGIT_9) begin
          // Digits only count in manual mode
          if (mode_flag) begin
            digit_acc_next      = (digit_sum > {3'b000, MAX_ANGLE}) ? MAX_ANGLE
                                                                    : digit_sum[7:0];
            number_pending_next = 1'b1;
          end
        end else begin
          // Any other byte applies a pending number
          if (number_pending) begin
            target_next         = digit_acc;
            digit_acc_next      = '0;
            number_pending_next = 1'b0;
          end
          if (in_char == CHAR_LOWER_A || in_char == CHAR_UPPER_A) begin
            mode_flag_next = 1'b0;
          end else if (in_char == CHAR_LOWER_M || in_char == CHAR_UPPER_M) begin
            mode_flag_next = 1'b1;
          end
        end
      end
      CMD_TEMP: begin
        if (!mode_flag) begin
          if (in_temp < low_threshold) begin
            target_next = clip_angle(cool_angle);
          end else if (in_temp > high_threshold) begin
            target_next = clip_angle(hot_angle);
          end
        end
      end
      default: ;
    endcase
  end

  // Update state on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_flag      <= 1'b0;
      current_angle  <= HOME_ANGLE;
      target         <= HOME_ANGLE;
      tick_count     <= '0;
      digit_acc      <= '0;
      number_pending <= 1'b0;
    end else if (in_accept) begin
      mode_flag      <= mode_flag_next;
      current_angle  <= current_angle_next;
      target         <= target_next;
      tick_count     <= tick_count_next;
      digit_acc      <= digit_acc_next;
      number_pending <= number_pending_next;
    end
  end

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data <= {6'd0, target_next, mode_flag_next,
                   (current_angle_next != current_angle), current_angle_next};
    end
  end

  // Checks
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> m_axis_tvalid)
    else $error("accepted request produced no result");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (current_angle <= MAX_ANGLE) && (target <= MAX_ANGLE))
    else $error("angle or target beyond limit");

  a_digits_idle: assert property (@(posedge clk) disable iff (rst)
    !number_pending |-> (digit_acc == '0))
    else $error("digit accumulator dirty with no number pending");

  a_write_flag: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (m_axis_tdata[8] == (current_angle != $past(current_angle))))
    else $error("angle-changed flag does not match angle update");

endmodule

### tb/servo_status_checker.sv
// ============================================================================
// servo_status_checker - result checker for the servo slew positioner
// Mirrors the registers and the positioner state from the request and
// configuration traffic, works out the status each request must return and
// compares every returned status field by field, in order.
// ============================================================================
module servo_status_checker
  import ssp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] char_code, [19:8] temperature
  input  logic [IN_USER_W-1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] servo_angle, [8] servo_write,
                                                // [9] mode_bit, [17:10] target_angle
  output int                    mismatches,
  output int                    in_flight
);

  // Status word, lowest field last so the cast matches the tdata layout
  typedef struct packed {
    logic [ANGLE_W-1:0] target;
    logic               manual;
    logic               moved;
    logic [ANGLE_W-1:0] angle;
  } servo_status_t;

  // Register shadow
  logic [INTERVAL_W-1:0]    interval_r;
  logic [ANGLE_W-1:0]       size_r;
  logic [ANGLE_W-1:0]       cool_r;
  logic [ANGLE_W-1:0]       hot_r;
  logic signed [TEMP_W-1:0] low_r;
  logic signed [TEMP_W-1:0] high_r;

  // Positioner state
  logic                     manual_r;
  logic [ANGLE_W-1:0]       angle_r;
  logic [ANGLE_W-1:0]       target_r;
  logic [INTERVAL_W-1:0]    ticks_r;
  logic [ANGLE_W-1:0]       digits_r;
  logic                     number_r;

  servo_status_t            pending_status[$];
  servo_status_t            want_st;
  servo_status_t            got_st;

  initial begin
    mismatches = 0;
    in_flight  = 0;
  end

  function automatic logic [ANGLE_W-1:0] limit_angle(input int a);
    return (a > int'(MAX_ANGLE)) ? MAX_ANGLE : a[ANGLE_W-1:0];
  endfunction

  // Load a typed number into the target and drop it
  task automatic commit_number();
    if (number_r) begin
      target_r = digits_r;
      digits_r = '0;
      number_r = 1'b0;
    end
  endtask

  // Advance the positioner by one request and return its status
  task automatic step_positioner(input logic [IN_USER_W-1:0] kind,
                                 input logic [CHAR_W-1:0] ch,
                                 input logic signed [TEMP_W-1:0] temp,
                                 output servo_status_t st);
    logic [ANGLE_W-1:0] prior;
    int                 span;
    int                 move;
    prior = angle_r;
    case (kind)
      CMD_TICK: begin
        if (int'(ticks_r) + 1 >= int'(interval_r)) begin
          ticks_r = '0;
          // Move toward the target, never past it
          span = int'(target_r) - int'(angle_r);
          move = (span < 0) ? -span : span;
          if (move > int'(size_r)) move = int'(size_r);
          angle_r = (span < 0) ? ANGLE_W'(int'(angle_r) - move)
                               : ANGLE_W'(int'(angle_r) + move);
        end else begin
          ticks_r = ticks_r + 1'b1;
        end
      end
      CMD_BYTE: begin
        if (ch == CHAR_LOWER_A || ch == CHAR_UPPER_A) begin
          commit_number();
          manual_r = 1'b0;
        end else if (ch == CHAR_LOWER_M || ch == CHAR_UPPER_M) begin
          commit_number();
          manual_r = 1'b1;
        end else if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
          // Digits only count in manual mode
          if (manual_r) begin
            digits_r = limit_angle(int'(digits_r) * 10 + int'(ch - CHAR_DIGIT_0));
            number_r = 1'b1;
          end
        end else begin
          commit_number();
        end
      end
      CMD_TEMP: begin
        if (!manual_r) begin
          if (temp < low_r) target_r = limit_angle(int'(cool_r));
          else if (temp > high_r) target_r = limit_angle(int'(hot_r));
        end
      end
      default: ;
    endcase
    st.angle  = angle_r;
    st.moved  = (angle_r != prior);
    st.manual = manual_r;
    st.target = target_r;
  endtask

  task automatic compare_field(input string label, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      interval_r = STEP_INTERVAL_RST;
      size_r     = STEP_SIZE_RST;
      cool_r     = COOL_ANGLE_RST;
      hot_r      = HOT_ANGLE_RST;
      low_r      = LOW_THR_RST;
      high_r     = HIGH_THR_RST;
      manual_r   = 1'b0;
      angle_r    = HOME_ANGLE;
      target_r   = HOME_ANGLE;
      ticks_r    = '0;
      digits_r   = '0;
      number_r   = 1'b0;
      pending_status.delete();
    end else begin
      // Check a returned status against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got_st = servo_status_t'(m_axis_tdata[$bits(servo_status_t)-1:0]);
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want_st = pending_status.pop_front();
          compare_field("servo_angle", want_st.angle, got_st.angle);
          compare_field("servo_write", want_st.moved, got_st.moved);
          compare_field("mode_bit", want_st.manual, got_st.manual);
          compare_field("target_angle", want_st.target, got_st.target);
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_INTERVAL:  interval_r = cfg_data[INTERVAL_W-1:0];
          REG_STEP_SIZE:      size_r     = cfg_data[ANGLE_W-1:0];
          REG_COOL_ANGLE:     cool_r     = cfg_data[ANGLE_W-1:0];
          REG_HOT_ANGLE:      hot_r      = cfg_data[ANGLE_W-1:0];
          REG_LOW_THRESHOLD:  low_r      = cfg_data[TEMP_W-1:0];
          REG_HIGH_THRESHOLD: high_r     = cfg_data[TEMP_W-1:0];
          default: ;
        endcase
      end
      // Predict the status of an accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        step_positioner(s_axis_tuser, s_axis_tdata[CHAR_W-1:0],
                        s_axis_tdata[CHAR_W+TEMP_W-1:CHAR_W], want_st);
        pending_status.push_back(want_st);
      end
    end
    in_flight = pending_status.size();
  end

endmodule

### tb/servo_slew_positioner_top_tb.sv
// ============================================================================
// servo_slew_positioner_top_tb - stimulus and verdict for the positioner
// Sends directed and random tick, serial and temperature requests in bursts
// under several register settings while the result side stalls on its own
// pattern; the status checker predicts and compares every result.
// ============================================================================
module servo_slew_positioner_top_tb;
  import ssp_pkg::*;

  localparam logic [IN_USER_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS   = 170;
  localparam int NUM_PHASES    = 9;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] char_code, [19:8] temperature
  logic [IN_USER_W-1:0]  s_axis_tuser;   // [1:0] cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] servo_angle, [8] servo_write,
                                         // [9] mode_bit, [17:10] target_angle
  int                    mismatches;
  int                    in_flight;

  int                       burst_left = 0;
  int                       requests_sent = 0;
  rx_pattern_t              rx_mode = RX_OPEN;
  int                       rx_left = 0;
  int                       rx_count = 0;
  logic signed [TEMP_W-1:0] low_set = LOW_THR_RST;
  logic signed [TEMP_W-1:0] high_set = HIGH_THR_RST;

  servo_slew_positioner_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  servo_status_checker status_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches    (mismatches),
    .in_flight     (in_flight)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Result side: switch between ready patterns every so often
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_pattern_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    rx_count++;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default:   m_axis_tready <= (rx_count % 6) < 2;
    endcase
  end

  // Hard stop for a hung run
  initial begin
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] rand_char();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [TEMP_W-1:0] rand_temp();
    return TEMP_W'($urandom_range(0, 4095));
  endfunction

  // Send one request, opening a new burst after a random gap when due
  task automatic push_request(input logic [IN_USER_W-1:0] kind,
                              input logic [CHAR_W-1:0] ch,
                              input logic signed [TEMP_W-1:0] temp);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W-TEMP_W-CHAR_W){1'b0}}, temp, ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic push_byte(input logic [CHAR_W-1:0] ch);
    push_request(CMD_BYTE, ch, rand_temp());
  endtask

  task automatic push_temp(input logic signed [TEMP_W-1:0] temp);
    push_request(CMD_TEMP, rand_char(), temp);
  endtask

  task automatic push_tick();
    push_request(CMD_TICK, rand_char(), rand_temp());
  endtask

  // Drop valid and hold until every status is back and the block is quiet
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_settings(input int itv, input int sz, input int cool,
                                input int hot, input int lo, input int hi);
    write_reg(REG_STEP_INTERVAL, itv);
    write_reg(REG_STEP_SIZE, sz);
    write_reg(REG_COOL_ANGLE, cool);
    write_reg(REG_HOT_ANGLE, hot);
    write_reg(REG_LOW_THRESHOLD, lo);
    write_reg(REG_HIGH_THRESHOLD, hi);
    cfg_we   <= 1'b0;
    low_set  = lo[TEMP_W-1:0];
    high_set = hi[TEMP_W-1:0];
  endtask

  task automatic choose_settings(input int phase);
    int lo;
    int hi;
    case (phase)
      1: apply_settings(1, 180, 180, 0, -2048, 2047);
      // zero interval steps on every tick, zero size never moves
      2: apply_settings(0, 0, 0, 180, 0, 0);
      3: apply_settings(1000, 1, 90, 0, 480, 800);
      // angle registers above the limit saturate when applied to the target
      4: apply_settings(2, 7, 255, 200, -100, 100);
      // crossed thresholds
      5: apply_settings(3, 5, 30, 150, 2047, -2048);
      6: apply_settings(0, 3, $urandom_range(0, 180), $urandom_range(0, 180), -16, 16);
      default: begin
        lo = int'($urandom_range(0, 4095)) - 2048;
        hi = lo + int'($urandom_range(0, 400));
        if (hi > 2047) hi = 2047;
        apply_settings(($urandom_range(0, 4) == 0) ? $urandom_range(1, 1000)
                                                   : $urandom_range(1, 6),
                       $urandom_range(1, 180),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(181, 255)
                                                   : $urandom_range(0, 180),
                       $urandom_range(0, 180), lo, hi);
      end
    endcase
  endtask

  // Field extremes, both modes, number entry and each corner of the decoder
  task automatic directed_items();
    push_tick();
    push_temp(-12'sd2048);
    push_temp(12'sd2047);
    push_temp(LOW_THR_RST);
    push_temp(HIGH_THR_RST);
    push_byte(CHAR_UPPER_M);
    push_temp(-12'sd2048);          // ignored in manual mode
    push_byte(CHAR_DIGIT_0 + 8'd1);
    push_byte(CHAR_DIGIT_0 + 8'd2);
    push_byte(CHAR_DIGIT_0 + 8'd3);
    push_byte(8'h00);               // terminator applies the number
    push_byte(CHAR_DIGIT_9);
    push_byte(CHAR_DIGIT_9);
    push_byte(CHAR_DIGIT_9);        // saturates at the limit
    push_byte(CHAR_LOWER_A);        // applies the number, back to auto
    push_byte(CHAR_DIGIT_0 + 8'd5); // ignored in auto mode
    push_byte(8'hFF);               // nothing pending
    push_byte(CHAR_UPPER_A);
    push_byte(CHAR_LOWER_M);
    push_byte(CHAR_DIGIT_0);
    push_byte(CHAR_UPPER_A);
    push_request(CMD_UNUSED, 8'hFF, 12'sh7FF);
    repeat (4) push_tick();
  endtask

  // Mostly well-formed traffic: ticks, temperatures and typed numbers
  task automatic random_items(input int count);
    int               goal;
    int               pick;
    logic [CHAR_W-1:0] ch;
    goal = requests_sent + count;
    while (requests_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 38) begin
        push_tick();
      end else if (pick < 58) begin
        if ($urandom_range(0, 1)) push_temp(rand_temp());
        else push_temp(TEMP_W'(($urandom_range(0, 1) ? low_set : high_set)
                               + $urandom_range(0, 6) - 3));
      end else if (pick < 86) begin
        // Typed number: optional mode letter, digits, terminator
        if ($urandom_range(0, 9) < 7)
          push_byte($urandom_range(0, 1) ? CHAR_LOWER_M : CHAR_UPPER_M);
        repeat ($urandom_range(1, 4))
          push_byte(CHAR_W'(CHAR_DIGIT_0 + $urandom_range(0, 9)));
        case ($urandom_range(0, 5))
          0: ch = CHAR_LOWER_A;
          1: ch = CHAR_UPPER_A;
          2: ch = CHAR_LOWER_M;
          3: ch = 8'h0D;
          4: ch = 8'h20;
          default: begin
            ch = rand_char();
            if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) ch = 8'h2C;
          end
        endcase
        push_byte(ch);
      end else if (pick < 94) begin
        case ($urandom_range(0, 3))
          0: push_byte(CHAR_LOWER_A);
          1: push_byte(CHAR_UPPER_A);
          2: push_byte(CHAR_LOWER_M);
          default: push_byte(CHAR_UPPER_M);
        endcase
      end else if (pick < 98) begin
        push_byte(rand_char());
      end else begin
        push_request(CMD_UNUSED, rand_char(), rand_temp());
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_STEP_INTERVAL;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    directed_items();
    wait_idle();
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) choose_settings(phase);
      random_items(PHASE_ITEMS);
      wait_idle();
    end
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
